[hdl/scrc_pkg.sv]
package scrc_pkg;

  localparam int unsigned SECTOR_BYTES  = 4096;
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [31:0] MAGIC_RESET   = 32'h3353_4354;
  localparam int          LEN_W         = 12;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 12'd2032;

  // Byte positions reach the stored CRC word of the longest record, past 4096.
  localparam int          POS_W         = LEN_W + 1;
  localparam logic [POS_W-1:0] HDR_BYTES     = 13'd12;
  localparam logic [POS_W-1:0] POS_MAGIC_END = 13'd3;
  localparam logic [POS_W-1:0] POS_SEQ_END   = 13'd7;
  localparam logic [POS_W-1:0] POS_LEN_END   = 13'd11;

  localparam int          REG_W         = 1;
  localparam logic [REG_W-1:0] REG_MAGIC     = 1'b0;
  localparam logic [REG_W-1:0] REG_MAX_LEN   = 1'b1;

  localparam int          OUT_DATA_W    = 48;

  typedef enum logic [1:0] {
    ST_VALID     = 2'd0,
    ST_BAD_MAGIC = 2'd1,
    ST_BAD_LEN   = 2'd2,
    ST_CRC_BAD   = 2'd3
  } status_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

[hdl/save_record_crc_checker.sv]
// Checks a save sector streamed one byte per item, tuser high on byte 0 of
// each sector. The block takes one byte every cycle with no gaps unless a
// pending verdict is stalled on the output side: the CRC-32 update is unrolled
// over the eight bits of a byte and feeds the running state registers, and the
// verdict appears on out_* the cycle after the deciding byte.
// At most one verdict per sector is produced: on byte 3 for a bad magic, on
// byte 11 for a bad length, or on the last byte of the stored CRC word. A
// pending verdict does not stop the input unless the output side is stalled
// too. Bytes before the first tuser mark or after the verdict are consumed
// and dropped. Write the magic word and maximum length only while idle.
module save_record_crc_checker
  import scrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_we,
  input  logic [REG_W-1:0]      cfg_addr,
  input  logic [31:0]           cfg_wdata,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic                  in_tuser,   // [0] first_byte

  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [1:0] status, [13:2] body_len,
                                            // [45:14] sequence_res, [47:46] zero
);

  logic [31:0]      magic_r;
  logic [LEN_W-1:0] max_len_r;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic [31:0]      ws_r, ws_nxt;
  logic [31:0]      seq_r, seq_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [POS_W-1:0] off_r, off_nxt;
  logic             done_r, done_nxt;

  logic             out_valid_r;
  status_t          out_status_r;
  logic [LEN_W-1:0] out_len_r;
  logic [31:0]      out_seq_r;

  logic             acc;
  logic [POS_W-1:0] pos_e;
  logic [31:0]      crc_e;
  logic [31:0]      ws_e;
  logic             done_e;
  logic [31:0]      ws_shift;
  logic [31:0]      crc_b;
  logic [POS_W-1:0] off_sum;
  logic [POS_W-1:0] off_calc;
  logic [POS_W:0]   end_calc;
  logic             emit;
  status_t          status_v;

  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;

  assign pos_e    = in_tuser ? '0 : pos_r;
  assign crc_e    = in_tuser ? CRC_INIT : crc_r;
  assign ws_e     = in_tuser ? 32'd0 : ws_r;
  assign done_e   = in_tuser ? 1'b0 : done_r;
  assign ws_shift = {in_tdata, ws_e[31:8]};
  assign crc_b    = crc_byte(crc_e, in_tdata);

  assign off_sum  = POS_W'(ws_shift[LEN_W-1:0]) + HDR_BYTES + POS_W'(3);
  assign off_calc = {off_sum[POS_W-1:2], 2'b00};
  assign end_calc = {1'b0, off_calc} + (POS_W+1)'(4);

  always_comb begin
    pos_nxt  = pos_r;
    crc_nxt  = crc_r;
    ws_nxt   = ws_r;
    seq_nxt  = seq_r;
    len_nxt  = len_r;
    off_nxt  = off_r;
    done_nxt = done_r;
    emit     = 1'b0;
    status_v = ST_VALID;
    if (acc) begin
      pos_nxt  = pos_e;
      crc_nxt  = crc_e;
      ws_nxt   = ws_e;
      done_nxt = done_e;
      if (!done_e) begin
        pos_nxt = pos_e + POS_W'(1);
        ws_nxt  = ws_shift;
        if (pos_e < HDR_BYTES) begin
          crc_nxt = crc_b;
          case (pos_e)
            POS_MAGIC_END: begin
              if (ws_shift != magic_r) begin
                emit     = 1'b1;
                status_v = ST_BAD_MAGIC;
              end
            end
            POS_SEQ_END: begin
              seq_nxt = ws_shift;
            end
            POS_LEN_END: begin
              if (ws_shift == 32'd0 || ws_shift > {20'd0, max_len_r}) begin
                emit     = 1'b1;
                status_v = ST_BAD_LEN;
              end else begin
                len_nxt = ws_shift[LEN_W-1:0];
                off_nxt = off_calc;
                if (32'(end_calc) > SECTOR_BYTES) begin
                  emit     = 1'b1;
                  status_v = ST_BAD_LEN;
                end
              end
            end
            default: begin
            end
          endcase
        end else if (pos_e < off_r) begin
          crc_nxt = crc_b;
        end else if (pos_e == off_r + POS_W'(3)) begin
          emit     = 1'b1;
          status_v = ((crc_e ^ CRC_INIT) == ws_shift) ? ST_VALID : ST_CRC_BAD;
        end
      end
      if (emit) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= MAGIC_RESET;
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MAGIC:   magic_r   <= cfg_wdata;
        REG_MAX_LEN: max_len_r <= cfg_wdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      crc_r  <= CRC_INIT;
      ws_r   <= '0;
      done_r <= 1'b1;
    end else begin
      pos_r  <= pos_nxt;
      crc_r  <= crc_nxt;
      ws_r   <= ws_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r <= seq_nxt;
    len_r <= len_nxt;
    off_r <= off_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && emit) begin
      out_status_r <= status_v;
      out_len_r    <= (status_v == ST_VALID) ? len_r : '0;
      out_seq_r    <= (status_v == ST_VALID) ? seq_r : 32'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_seq_r, out_len_r, out_status_r};

  a_err_clears_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_VALID) |-> (out_len_r == '0 && out_seq_r == 32'd0))
    else $error("rejected verdict carries a length or sequence");

  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(acc && emit))
    else $error("verdict appeared without a deciding item");

  a_verdict_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && emit) |=> done_r)
    else $error("sector still open after its verdict");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with an empty result register");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import scrc_pkg::*;

  localparam int HOLD_CYCLES = 400;

  typedef struct {
    status_t     status;
    logic [11:0] body_len;
    logic [31:0] seq;
  } verdict_t;

  typedef struct {
    int          lead;
    logic [31:0] magic;
    logic [31:0] seq;
    logic [31:0] len;
    bit          crc_ok;
    int          cut;
    int          tail;
    bit          known;
    status_t     status;
    logic [11:0] body_len;
    logic [31:0] bseq;
  } case_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [REG_W-1:0]      cfg_addr = REG_MAGIC;
  logic [31:0]           cfg_wdata = 32'd0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = 8'd0;   // [7:0] data_byte
  logic                  in_tuser = 1'b0;   // [0] first_byte
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // [1:0] status, [13:2] body_len,
                                            // [45:14] sequence_res

  save_record_crc_checker DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Shadow of the checker: configuration and per-sector tracking state.
  logic [31:0] magic_cfg = MAGIC_RESET;
  logic [11:0] max_len_cfg = MAX_LEN_RESET;
  logic [31:0] rec_pos = 32'd0;
  logic [31:0] crc_acc = CRC_INIT;
  logic [31:0] word_sr = 32'd0;
  logic [31:0] seq_cap = 32'd0;
  logic [31:0] len_cap = 32'd0;
  bit          sector_idle = 1'b1;

  verdict_t    verdict_q[$];
  bit          pinned = 1'b0;
  verdict_t    pinned_v;
  int          errs = 0;
  int unsigned bytes_used = 0;
  bit          calm = 1'b0;
  bit          hold_out = 1'b0;
  logic [7:0]  img[$];

  case_row_t plan [0:11] = '{
    '{3, MAGIC_RESET, 32'h0, 32'd1, 1'b1, 0, 2, 1'b1, ST_VALID, 12'd1, 32'h0},
    '{0, MAGIC_RESET, 32'hFFFF_FFFF, 32'd2, 1'b1, 0, 4, 1'b1, ST_VALID, 12'd2,
      32'hFFFF_FFFF},
    '{0, MAGIC_RESET ^ 32'h1, 32'h5, 32'd0, 1'b1, 0, 2, 1'b1, ST_BAD_MAGIC, 12'd0, 32'h0},
    '{0, 32'h0, 32'h6, 32'd4, 1'b1, 0, 0, 1'b1, ST_BAD_MAGIC, 12'd0, 32'h0},
    '{0, MAGIC_RESET, 32'h77, 32'd0, 1'b1, 0, 1, 1'b1, ST_BAD_LEN, 12'd0, 32'h0},
    '{0, MAGIC_RESET, 32'h78, 32'd2033, 1'b1, 0, 1, 1'b1, ST_BAD_LEN, 12'd0, 32'h0},
    '{0, MAGIC_RESET, 32'h79, 32'hFFFF_FFFF, 1'b1, 0, 0, 1'b1, ST_BAD_LEN, 12'd0, 32'h0},
    '{0, MAGIC_RESET, 32'h1234_5678, 32'd5, 1'b0, 0, 2, 1'b1, ST_CRC_BAD, 12'd0, 32'h0},
    '{0, MAGIC_RESET, 32'hA5, 32'd8, 1'b1, 10, 0, 1'b0, ST_VALID, 12'd0, 32'h0},
    '{0, MAGIC_RESET, 32'hA6, 32'd8, 1'b1, 15, 0, 1'b0, ST_VALID, 12'd0, 32'h0},
    '{0, MAGIC_RESET, 32'hDEAD_BEEF, 32'd3, 1'b1, 0, 0, 1'b1, ST_VALID, 12'd3,
      32'hDEAD_BEEF},
    '{0, MAGIC_RESET, 32'h8000_0001, 32'd4, 1'b1, 0, 3, 1'b1, ST_VALID, 12'd4,
      32'h8000_0001}
  };

  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    logic        fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r = r >> 1;
      if (fb) r = r ^ 32'hEDB8_8320;
    end
    return r;
  endfunction

  function automatic void post_verdict(input status_t st);
    verdict_t v;
    v.status = st;
    v.body_len = (st == ST_VALID) ? len_cap[11:0] : 12'd0;
    v.seq = (st == ST_VALID) ? seq_cap : 32'd0;
    if (pinned) begin
      v = pinned_v;
      pinned = 1'b0;
    end
    verdict_q.push_back(v);
    sector_idle = 1'b1;
  endfunction

  // Returns 1 when the byte takes part in a sector check.
  function automatic bit track_byte(input logic [7:0] b, input logic first);
    logic [31:0] pos;
    logic [31:0] crc_start;
    if (first) begin
      rec_pos = 32'd0;
      crc_acc = CRC_INIT;
      word_sr = 32'd0;
      seq_cap = 32'd0;
      len_cap = 32'd0;
      sector_idle = 1'b0;
    end
    if (sector_idle) return 1'b0;
    pos = rec_pos;
    rec_pos = pos + 32'd1;
    word_sr = {b, word_sr[31:8]};
    if (pos < 32'd12) begin
      crc_acc = crc_step(crc_acc, b);
      if (pos == 32'd3) begin
        if (word_sr != magic_cfg) post_verdict(ST_BAD_MAGIC);
      end else if (pos == 32'd7) begin
        seq_cap = word_sr;
      end else if (pos == 32'd11) begin
        if (word_sr == 32'd0 || word_sr > {20'd0, max_len_cfg}) begin
          post_verdict(ST_BAD_LEN);
        end else begin
          len_cap = word_sr;
          crc_start = (32'd12 + word_sr + 32'd3) & ~32'd3;
          if (crc_start + 32'd4 > SECTOR_BYTES) post_verdict(ST_BAD_LEN);
        end
      end
      return 1'b1;
    end
    crc_start = (32'd12 + len_cap + 32'd3) & ~32'd3;
    if (pos < crc_start) begin
      crc_acc = crc_step(crc_acc, b);
    end else if (pos == crc_start + 32'd3) begin
      post_verdict((~crc_acc == word_sr) ? ST_VALID : ST_CRC_BAD);
    end
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Builds a sector image; body, pad and CRC only when the magic matches and the length lies in 1..max_len_cfg.
  function automatic void build_image(input logic [31:0] magic, input logic [31:0] seq,
                                      input logic [31:0] len, input bit crc_ok);
    logic [31:0] words [3];
    logic [31:0] crc;
    img.delete();
    words[0] = magic;
    words[1] = seq;
    words[2] = len;
    for (int w = 0; w < 3; w++)
      for (int k = 0; k < 4; k++) img.push_back(words[w][8*k +: 8]);
    if (magic != magic_cfg || len == 32'd0 || len > {20'd0, max_len_cfg}) return;
    for (int i = 0; i < int'(len); i++) img.push_back(8'($urandom));
    while (img.size() % 4 != 0) img.push_back(8'($urandom));
    crc = CRC_INIT;
    foreach (img[i]) crc = crc_step(crc, img[i]);
    crc = ~crc;
    if (!crc_ok) crc = crc ^ (32'd1 << $urandom_range(0, 31));
    for (int k = 0; k < 4; k++) img.push_back(crc[8*k +: 8]);
  endfunction

  task automatic send_item(input logic [7:0] b, input logic first);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (track_byte(b, first)) bytes_used++;
  endtask

  task automatic send_image(input int cut, input int tail);
    int n;
    n = (cut > 0 && cut < img.size()) ? cut : img.size();
    for (int i = 0; i < n; i++) send_item(img[i], i == 0);
    repeat (tail) send_item(8'($urandom), 1'b0);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAGIC) magic_cfg = val;
    else max_len_cfg = val[11:0];
  endtask

  function automatic logic [31:0] pick_len();
    int unsigned hi;
    hi = (max_len_cfg < 12'd40) ? max_len_cfg : 40;
    if ($urandom_range(0, 19) == 0 && max_len_cfg > 12'd40)
      hi = (max_len_cfg < 12'd300) ? max_len_cfg : 300;
    return $urandom_range(1, hi);
  endfunction

  function automatic logic [31:0] pick_seq();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_record();
    int          r;
    int          cut;
    int          tail;
    logic [31:0] magic;
    logic [31:0] len;
    logic [31:0] flip;
    bit          ok;
    r = $urandom_range(0, 99);
    magic = magic_cfg;
    len = pick_len();
    ok = 1'b1;
    cut = 0;
    tail = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 40) : $urandom_range(0, 3);
    if (r < 8) begin
      ok = 1'b0;
    end else if (r < 14) begin
      flip = $urandom;
      if (flip == 32'd0) flip = 32'd1;
      magic = magic_cfg ^ flip;
    end else if (r < 20) begin
      case ($urandom_range(0, 3))
        0: len = 32'd0;
        1: len = {20'd0, max_len_cfg} + 32'd1;
        2: len = 32'hFFFF_FFFF;
        default: len = $urandom | 32'h0000_1000;
      endcase
    end else if (r < 25) begin
      cut = 1;
    end else if (r < 30) begin
      repeat ($urandom_range(1, 6)) send_item(8'($urandom), $urandom_range(0, 19) == 0);
      return;
    end
    build_image(magic, pick_seq(), len, ok);
    if (cut != 0) begin
      cut = $urandom_range(1, img.size() - 1);
      tail = 0;
    end
    send_image(cut, tail);
    if ($urandom_range(0, 49) == 0) drain();
  endtask

  task automatic run_phase(input int unsigned budget);
    int unsigned stop;
    stop = bytes_used + budget;
    while (bytes_used < stop) random_record();
    build_image(magic_cfg, pick_seq(), pick_len(), 1'b1);
    send_image(0, 1);
    drain();
  endtask

  initial begin : receiver
    int stall;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_out = 1'b0;
      end
      stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : verdict_check
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        errs++;
        $error("unexpected verdict: status %0d", out_tdata[1:0]);
      end else begin
        want = verdict_q.pop_front();
        if (out_tdata[1:0] !== want.status) begin
          errs++;
          $error("status: expected %0d, actual %0d", want.status, out_tdata[1:0]);
        end
        if (out_tdata[13:2] !== want.body_len) begin
          errs++;
          $error("body_len: expected %0d, actual %0d", want.body_len, out_tdata[13:2]);
        end
        if (out_tdata[45:14] !== want.seq) begin
          errs++;
          $error("sequence_res: expected %h, actual %h", want.seq, out_tdata[45:14]);
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < 12; k++) begin
      repeat (plan[k].lead) send_item(8'($urandom), 1'b0);
      pinned = plan[k].known;
      pinned_v.status = plan[k].status;
      pinned_v.body_len = plan[k].body_len;
      pinned_v.seq = plan[k].bseq;
      build_image(plan[k].magic, plan[k].seq, plan[k].len, plan[k].crc_ok);
      send_image(plan[k].cut, plan[k].tail);
      pinned = 1'b0;
    end
    drain();

    run_phase(200);

    write_reg(REG_MAGIC, 32'h0);
    write_reg(REG_MAX_LEN, 32'd1);
    run_phase(200);

    write_reg(REG_MAGIC, 32'hFFFF_FFFF);
    write_reg(REG_MAX_LEN, 32'd4080);
    run_phase(200);

    write_reg(REG_MAGIC, $urandom);
    write_reg(REG_MAX_LEN, $urandom_range(1, 4080));
    calm = 1'b1;
    run_phase(200);
    calm = 1'b0;

    write_reg(REG_MAGIC, MAGIC_RESET);
    write_reg(REG_MAX_LEN, {20'd0, MAX_LEN_RESET});
    // Short failing sectors while the output is held off fill the checker.
    hold_out = 1'b1;
    repeat (24) begin
      build_image(magic_cfg ^ 32'h8000_0000, $urandom, 32'd1, 1'b1);
      send_image(4, 0);
    end
    run_phase(200);

    repeat (20) @(posedge clk);
    if (errs == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[save_record_crc_checker.f]
hdl/scrc_pkg.sv
hdl/save_record_crc_checker.sv
bench/tb_top.sv
